### sv/vmdt_pkg.sv
// vmdt_pkg: payload structs, coefficient bundle, register indexes and helpers
// for the drift / thermal moments pipeline. No dependencies.
package vmdt_pkg;

  localparam int NODES    = 2;
  localparam int DW       = 32;
  localparam int CFG_IW   = 4;
  localparam int DIV_QB   = 33;            // quotient magnitude bits per divide
  localparam int DIV_LAT  = DIV_QB + 2;    // prep, one stage per bit, saturate
  localparam int PROJ_LAT = 6;
  localparam int PIPE_LAT = DIV_LAT + PROJ_LAT;

  typedef enum logic [CFG_IW-1:0] {
    REG_UI_Q0N0 = 4'd0,
    REG_UI_Q0N1 = 4'd1,
    REG_UI_Q1N0 = 4'd2,
    REG_UI_Q1N1 = 4'd3,
    REG_PJ_N0Q0 = 4'd4,
    REG_PJ_N0Q1 = 4'd5,
    REG_PJ_N1Q0 = 4'd6,
    REG_PJ_N1Q1 = 4'd7
  } vmdt_reg_t;

  typedef struct packed {
    logic signed [DW-1:0] density_n0;
    logic signed [DW-1:0] density_n1;
    logic signed [DW-1:0] momentum_n0;
    logic signed [DW-1:0] momentum_n1;
    logic signed [DW-1:0] second_moment_n0;
    logic signed [DW-1:0] second_moment_n1;
  } vmdt_in_t;

  typedef struct packed {
    logic signed [DW-1:0] drift_n0;
    logic signed [DW-1:0] drift_n1;
    logic signed [DW-1:0] thermal_sq_n0;
    logic signed [DW-1:0] thermal_sq_n1;
  } vmdt_out_t;

  typedef struct packed {
    logic signed [DW-1:0] ui_q0n0;
    logic signed [DW-1:0] ui_q0n1;
    logic signed [DW-1:0] ui_q1n0;
    logic signed [DW-1:0] ui_q1n1;
    logic signed [DW-1:0] pj_n0q0;
    logic signed [DW-1:0] pj_n0q1;
    logic signed [DW-1:0] pj_n1q0;
    logic signed [DW-1:0] pj_n1q1;
  } vmdt_coef_t;

  localparam logic signed [DW-1:0] S32_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] S32_MIN = {1'b1, {(DW-1){1'b0}}};

  function automatic logic signed [DW-1:0] sat32(input logic signed [65:0] x);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    hi = 66'(S32_MAX);
    lo = 66'(S32_MIN);
    if (x > hi) return S32_MAX;
    if (x < lo) return S32_MIN;
    return x[DW-1:0];
  endfunction

endpackage

### sv/vmdt_div.sv
// vmdt_div: pipelined restoring divider, (num * 2^FRAC_BITS) / den, truncated
// toward zero and saturated to 32 bits; zero when den is zero. Uses vmdt_pkg.
module vmdt_div import vmdt_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 adv,
  input  logic signed [DW-1:0] num,
  input  logic signed [DW-1:0] den,
  output logic signed [DW-1:0] quo
);

  localparam int XW = DW + FRAC_BITS;   // dividend magnitude width
  localparam int HW = XW - DIV_QB;      // bits above the quotient window
  localparam int RW = DW + 1;

  logic [DW:0]   nx, dx, nmag, dmag;
  logic [XW-1:0] dividend;
  logic [HW-1:0] hi;

  logic [RW-1:0]     rem_r  [DIV_QB+1];
  logic [DIV_QB-1:0] lo_r   [DIV_QB+1];
  logic [DIV_QB-1:0] q_r    [DIV_QB+1];
  logic [DW-1:0]     dm_r   [DIV_QB+1];
  logic              neg_r  [DIV_QB+1];
  logic              zero_r [DIV_QB+1];
  logic              ovf_r  [DIV_QB+1];
  logic signed [DW-1:0] quo_r;

  always_comb begin
    nx       = {num[DW-1], num};
    dx       = {den[DW-1], den};
    nmag     = nx[DW] ? -nx : nx;
    dmag     = dx[DW] ? -dx : dx;
    dividend = {nmag[DW-1:0], {FRAC_BITS{1'b0}}};
    hi       = dividend[XW-1:DIV_QB];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0]  <= {{(RW-HW){1'b0}}, hi};
      lo_r[0]   <= dividend[DIV_QB-1:0];
      q_r[0]    <= '0;
      dm_r[0]   <= dmag[DW-1:0];
      neg_r[0]  <= num[DW-1] ^ den[DW-1];
      zero_r[0] <= (den == '0);
      // quotient would not fit the window
      ovf_r[0]  <= ({{(RW-HW){1'b0}}, hi} >= {1'b0, dmag[DW-1:0]});
    end
  end

  for (genvar k = 0; k < DIV_QB; k++) begin : g_step
    logic [RW-1:0] trial;
    logic          ge;
    always_comb begin
      trial = {rem_r[k][DW-1:0], lo_r[k][DIV_QB-1]};
      ge    = (trial >= {1'b0, dm_r[k]});
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k+1]  <= ge ? trial - {1'b0, dm_r[k]} : trial;
        lo_r[k+1]   <= {lo_r[k][DIV_QB-2:0], 1'b0};
        q_r[k+1]    <= {q_r[k][DIV_QB-2:0], ge};
        dm_r[k+1]   <= dm_r[k];
        neg_r[k+1]  <= neg_r[k];
        zero_r[k+1] <= zero_r[k];
        ovf_r[k+1]  <= ovf_r[k];
      end
    end
  end

  logic [DIV_QB-1:0] mag;
  logic signed [DW-1:0] quo_nxt;
  always_comb begin
    mag = q_r[DIV_QB];
    if (zero_r[DIV_QB]) begin
      quo_nxt = '0;
    end else if (neg_r[DIV_QB]) begin
      // magnitude limit 2^31 taken as an unsigned value
      if (ovf_r[DIV_QB] || mag > {{(DIV_QB-DW){1'b0}}, S32_MIN}) quo_nxt = S32_MIN;
      else quo_nxt = -$signed(mag[DW-1:0]);
    end else begin
      if (ovf_r[DIV_QB] || mag > {{(DIV_QB-DW){1'b0}}, S32_MAX}) quo_nxt = S32_MAX;
      else quo_nxt = $signed(mag[DW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) quo_r <= quo_nxt;
  end

  assign quo = quo_r;

endmodule

### sv/vmdt_proj.sv
// vmdt_proj: interpolation to quadrature points, squaring, projection back to
// nodes and subtraction from the thermal term. Uses vmdt_pkg.
module vmdt_proj import vmdt_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 adv,
  input  vmdt_coef_t           coef,
  input  logic signed [DW-1:0] u0,
  input  logic signed [DW-1:0] u1,
  input  logic signed [DW-1:0] w0,
  input  logic signed [DW-1:0] w1,
  output vmdt_out_t            res
);

  localparam int PW = 2 * DW;

  // drift and thermal term ride along
  logic signed [DW-1:0] u0_r [PROJ_LAT-1];
  logic signed [DW-1:0] u1_r [PROJ_LAT-1];
  logic signed [DW-1:0] w0_r [PROJ_LAT-1];
  logic signed [DW-1:0] w1_r [PROJ_LAT-1];

  logic signed [PW-1:0] ip00_r, ip01_r, ip10_r, ip11_r;
  logic signed [DW-1:0] uq0_r, uq1_r;
  logic signed [PW-1:0] sqr0_r, sqr1_r;
  logic signed [PW-1:0] pp00_r, pp01_r, pp10_r, pp11_r;
  logic signed [DW-1:0] p0_r, p1_r;
  vmdt_out_t            res_r;

  logic signed [65:0] isum0, isum1, psum0, psum1, ssh0, ssh1;
  logic signed [DW-1:0] sq0, sq1;

  always_comb begin
    isum0 = (66'(ip00_r) + 66'(ip01_r)) >>> FRAC_BITS;
    isum1 = (66'(ip10_r) + 66'(ip11_r)) >>> FRAC_BITS;
    ssh0  = 66'(sqr0_r) >>> FRAC_BITS;
    ssh1  = 66'(sqr1_r) >>> FRAC_BITS;
    sq0   = sat32(ssh0);
    sq1   = sat32(ssh1);
    psum0 = (66'(pp00_r) + 66'(pp01_r)) >>> FRAC_BITS;
    psum1 = (66'(pp10_r) + 66'(pp11_r)) >>> FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      u0_r[0] <= u0;
      u1_r[0] <= u1;
      w0_r[0] <= w0;
      w1_r[0] <= w1;
      for (int i = 1; i < PROJ_LAT - 1; i++) begin
        u0_r[i] <= u0_r[i-1];
        u1_r[i] <= u1_r[i-1];
        w0_r[i] <= w0_r[i-1];
        w1_r[i] <= w1_r[i-1];
      end
      ip00_r <= coef.ui_q0n0 * u0;
      ip01_r <= coef.ui_q0n1 * u1;
      ip10_r <= coef.ui_q1n0 * u0;
      ip11_r <= coef.ui_q1n1 * u1;
      uq0_r  <= sat32(isum0);
      uq1_r  <= sat32(isum1);
      sqr0_r <= uq0_r * uq0_r;
      sqr1_r <= uq1_r * uq1_r;
      pp00_r <= coef.pj_n0q0 * sq0;
      pp01_r <= coef.pj_n0q1 * sq1;
      pp10_r <= coef.pj_n1q0 * sq0;
      pp11_r <= coef.pj_n1q1 * sq1;
      p0_r   <= sat32(psum0);
      p1_r   <= sat32(psum1);
      res_r.drift_n0      <= u0_r[PROJ_LAT-2];
      res_r.drift_n1      <= u1_r[PROJ_LAT-2];
      res_r.thermal_sq_n0 <= sat32(66'(w0_r[PROJ_LAT-2]) - 66'(p0_r));
      res_r.thermal_sq_n1 <= sat32(66'(w1_r[PROJ_LAT-2]) - 66'(p1_r));
    end
  end

  assign res = res_r;

endmodule

### sv/velocity_moments_to_drift_thermal_unit.sv
// Drift velocity and thermal velocity squared per two-node cell. One cell is
// taken per clock unless the output stalls; results pass through the
// bit-per-stage dividers (35 stages) followed by the
// six-stage interpolate / square / project multiplier chain. The whole
// pipeline halts while a finished beat waits at the output. Coefficients are to be
// written through the cfg port while idle; the block does not enforce it. Uses vmdt_pkg, vmdt_div, vmdt_proj.
module velocity_moments_to_drift_thermal_unit import vmdt_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  vmdt_in_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output vmdt_out_t         out_data,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_idx,
  input  logic [DW-1:0]     cfg_wdata
);

  vmdt_coef_t          coef_r;
  logic [PIPE_LAT-1:0] vld_r;
  logic                adv;
  logic signed [DW-1:0] u0, u1, w0, w1;

  assign out_valid = vld_r[PIPE_LAT-1];
  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[PIPE_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else if (cfg_we) begin
      case (vmdt_reg_t'(cfg_idx))
        REG_UI_Q0N0: coef_r.ui_q0n0 <= cfg_wdata;
        REG_UI_Q0N1: coef_r.ui_q0n1 <= cfg_wdata;
        REG_UI_Q1N0: coef_r.ui_q1n0 <= cfg_wdata;
        REG_UI_Q1N1: coef_r.ui_q1n1 <= cfg_wdata;
        REG_PJ_N0Q0: coef_r.pj_n0q0 <= cfg_wdata;
        REG_PJ_N0Q1: coef_r.pj_n0q1 <= cfg_wdata;
        REG_PJ_N1Q0: coef_r.pj_n1q0 <= cfg_wdata;
        REG_PJ_N1Q1: coef_r.pj_n1q1 <= cfg_wdata;
        default: ;
      endcase
    end
  end

  vmdt_div #(.FRAC_BITS(FRAC_BITS)) u_div_u0 (
    .clk(clk), .adv(adv), .num(in_data.momentum_n0), .den(in_data.density_n0), .quo(u0));
  vmdt_div #(.FRAC_BITS(FRAC_BITS)) u_div_u1 (
    .clk(clk), .adv(adv), .num(in_data.momentum_n1), .den(in_data.density_n1), .quo(u1));
  vmdt_div #(.FRAC_BITS(FRAC_BITS)) u_div_w0 (
    .clk(clk), .adv(adv), .num(in_data.second_moment_n0), .den(in_data.density_n0),
    .quo(w0));
  vmdt_div #(.FRAC_BITS(FRAC_BITS)) u_div_w1 (
    .clk(clk), .adv(adv), .num(in_data.second_moment_n1), .den(in_data.density_n1),
    .quo(w1));

  vmdt_proj #(.FRAC_BITS(FRAC_BITS)) u_proj (
    .clk(clk), .adv(adv), .coef(coef_r),
    .u0(u0), .u1(u1), .w0(w0), .w1(w1), .res(out_data));

  // a stalled pipeline keeps every beat in place
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("valid chain moved during stall");

  a_out_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("waiting result beat lost or changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> vld_r == '0)
    else $error("pipeline not empty after reset");

  a_entry: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> vld_r[0] == $past(in_valid))
    else $error("input beat not tracked");

endmodule

### bench/testbench.sv
// Testbench for velocity_moments_to_drift_thermal_unit: random and directed cells
// against an in-bench predictor of drift and thermal terms. Depends on vmdt_pkg.
`timescale 1ns / 1ps

class drift_thermal_board;
  vmdt_pkg::vmdt_out_t pending[$];
  int errors;

  function void note_cell(vmdt_pkg::vmdt_out_t exp_beat);
    pending.push_back(exp_beat);
  endfunction

  function void check_beat(vmdt_pkg::vmdt_out_t got);
    vmdt_pkg::vmdt_out_t exp_beat;
    if (pending.size() == 0) begin
      $error("result beat with nothing expected: %h", got);
      errors++;
      return;
    end
    exp_beat = pending.pop_front();
    if (got.drift_n0 !== exp_beat.drift_n0) begin
      $error("drift_n0 expected %h actual %h", exp_beat.drift_n0, got.drift_n0);
      errors++;
    end
    if (got.drift_n1 !== exp_beat.drift_n1) begin
      $error("drift_n1 expected %h actual %h", exp_beat.drift_n1, got.drift_n1);
      errors++;
    end
    if (got.thermal_sq_n0 !== exp_beat.thermal_sq_n0) begin
      $error("thermal_sq_n0 expected %h actual %h", exp_beat.thermal_sq_n0,
             got.thermal_sq_n0);
      errors++;
    end
    if (got.thermal_sq_n1 !== exp_beat.thermal_sq_n1) begin
      $error("thermal_sq_n1 expected %h actual %h", exp_beat.thermal_sq_n1,
             got.thermal_sq_n1);
      errors++;
    end
  endfunction
endclass

module testbench;
  import vmdt_pkg::*;

  localparam int FB = 16;
  localparam longint LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  vmdt_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  vmdt_out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IW-1:0] cfg_idx = '0;
  logic [DW-1:0] cfg_wdata = '0;

  longint cycles = 0;
  bit quiet_phase = 1'b0;
  drift_thermal_board board = new();
  logic signed [63:0] coef [8];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  velocity_moments_to_drift_thermal_unit #(.FRAC_BITS(FB)) dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  function automatic logic signed [127:0] sat_to32(logic signed [127:0] x);
    if (x > 128'sd2147483647) return 128'sd2147483647;
    if (x < -128'sd2147483648) return -128'sd2147483648;
    return x;
  endfunction

  // floor division by 2^FB is an arithmetic shift on an exact wide value
  function automatic logic signed [127:0] floor_q(logic signed [127:0] x);
    return x >>> FB;
  endfunction

  function automatic logic signed [127:0] quot_q(logic signed [31:0] num,
                                                 logic signed [31:0] den);
    logic signed [127:0] n;
    logic signed [127:0] d;
    n = 128'(num) <<< FB;
    d = 128'(den);
    return sat_to32(n / d);
  endfunction

  function automatic vmdt_out_t predict_cell(vmdt_in_t c);
    logic signed [127:0] drift [2];
    logic signed [127:0] w [2];
    logic signed [127:0] sq [2];
    logic signed [127:0] uq;
    logic signed [127:0] p;
    logic signed [31:0] m0 [2];
    logic signed [31:0] m1 [2];
    logic signed [31:0] m2 [2];
    vmdt_out_t r;
    m0[0] = c.density_n0; m0[1] = c.density_n1;
    m1[0] = c.momentum_n0; m1[1] = c.momentum_n1;
    m2[0] = c.second_moment_n0; m2[1] = c.second_moment_n1;
    for (int n = 0; n < 2; n++) begin
      if (m0[n] == 0) begin
        drift[n] = 0;
        w[n] = 0;
      end else begin
        drift[n] = quot_q(m1[n], m0[n]);
        w[n] = quot_q(m2[n], m0[n]);
      end
    end
    for (int q = 0; q < 2; q++) begin
      uq = sat_to32(floor_q(128'(coef[2*q]) * drift[0] + 128'(coef[2*q+1]) * drift[1]));
      uq = floor_q(uq * uq);
      sq[q] = (uq > 128'sd2147483647) ? 128'sd2147483647 : uq;
    end
    for (int n = 0; n < 2; n++) begin
      p = sat_to32(floor_q(128'(coef[4+2*n]) * sq[0] + 128'(coef[5+2*n]) * sq[1]));
      w[n] = sat_to32(w[n] - p);
    end
    r.drift_n0 = drift[0][31:0];
    r.drift_n1 = drift[1][31:0];
    r.thermal_sq_n0 = w[0][31:0];
    r.thermal_sq_n1 = w[1][31:0];
    return r;
  endfunction

  // one write beat on the cfg port; cfg_we drops again before the task returns
  task automatic write_coef(vmdt_reg_t idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    coef[int'(idx)] = $signed(val);
    @(negedge clk);
  endtask

  task automatic drain_pipe();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (PIPE_LAT + 5) @(negedge clk);
  endtask

  // valid stays up after a beat; the next call replaces or drops it
  task automatic send_cell(vmdt_in_t c);
    if (!quiet_phase) begin
      while ($urandom_range(99) < 11) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_cell(predict_cell(c));
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0;
      3: return 32'(int'($urandom_range(131072)) - 65536);
      4: return 32'h0001_0000;
      5: return 32'(int'($urandom_range(8388608)) - 4194304);
      default: return $urandom;
    endcase
  endfunction

  function automatic vmdt_in_t rand_cell();
    vmdt_in_t c;
    c.density_n0 = pick_word();
    c.density_n1 = pick_word();
    c.momentum_n0 = pick_word();
    c.momentum_n1 = pick_word();
    c.second_moment_n0 = pick_word();
    c.second_moment_n1 = pick_word();
    return c;
  endfunction

  task automatic random_coefs(bit extreme);
    for (int i = 0; i < 8; i++) begin
      if (extreme) write_coef(vmdt_reg_t'(i), (i % 2) ? 32'h7fff_ffff : 32'h8000_0000);
      else write_coef(vmdt_reg_t'(i), 32'(int'($urandom_range(131072)) - 65536));
    end
  endtask

  // sink: random stalls, none in the quiet stretch
  always @(negedge clk) begin
    if (rst_n) out_ready <= quiet_phase ? 1'b1 : ($urandom_range(99) >= 11);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid && out_ready) board.check_beat(out_data);
    if (cycles > LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    vmdt_in_t c;
    for (int i = 0; i < 8; i++) coef[i] = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // identity-like interpolation; projection weights 0.5, 0.5 for node 0 and -0.5, 1.0 for node 1
    write_coef(REG_UI_Q0N0, 32'h0001_0000);
    write_coef(REG_UI_Q0N1, 32'h0);
    write_coef(REG_UI_Q1N0, 32'h0);
    write_coef(REG_UI_Q1N1, 32'h0001_0000);
    write_coef(REG_PJ_N0Q0, 32'h0000_8000);
    write_coef(REG_PJ_N0Q1, 32'h0000_8000);
    write_coef(REG_PJ_N1Q0, 32'hffff_8000);
    write_coef(REG_PJ_N1Q1, 32'h0001_0000);

    // directed: zero density, quotient overflow, extremes
    c = '0; send_cell(c);
    c = '{32'h0, 32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'h1234_5678, 32'h8000_0000};
    send_cell(c);
    c = '{32'h1, 32'hffff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff};
    send_cell(c);
    c = '{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
          32'h8000_0000};
    send_cell(c);
    c = '{32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'hfffd_0000, 32'h0010_0000,
          32'h0001_0000};
    send_cell(c);
    c = '{32'hffff_0000, 32'h0000_0001, 32'h0000_8000, 32'h0, 32'h0, 32'hffff_ffff};
    send_cell(c);
    for (int i = 0; i < 10; i++) send_cell(rand_cell());

    // hold off until the pipe is empty, then swing to extreme weights
    drain_pipe();
    random_coefs(1'b1);
    for (int i = 0; i < 8; i++) send_cell(rand_cell());

    for (int ph = 0; ph < 5; ph++) begin
      drain_pipe();
      if (ph == 4) begin
        for (int i = 0; i < 8; i++) write_coef(vmdt_reg_t'(i), 32'h0);
      end else random_coefs(1'b0);
      quiet_phase = (ph == 2);
      for (int i = 0; i < 220; i++) send_cell(rand_cell());
      quiet_phase = 1'b0;
    end

    drain_pipe();
    if (board.errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule

### files.f
sv/vmdt_pkg.sv
sv/vmdt_div.sv
sv/vmdt_proj.sv
sv/velocity_moments_to_drift_thermal_unit.sv
bench/testbench.sv
